// ===== sv/kfli_pkg.sv =====
// shared types, codes and controller/datapath handshake structs
package kfli_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic CFG_FRAME_SPEED = 1'b0;
  localparam logic CFG_WRAP_LIMIT  = 1'b1;

  localparam logic [15:0] FRAME_SPEED_RST = 16'd256;
  localparam logic [15:0] WRAP_LIMIT_RST  = 16'd1280;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        key_time;
    logic signed [15:0] key_pos_x;
    logic signed [15:0] key_pos_y;
    logic signed [15:0] key_scale_x;
    logic signed [15:0] key_scale_y;
    logic [15:0]        time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_pos_x;
    logic signed [15:0] out_pos_y;
    logic signed [15:0] out_scale_x;
    logic signed [15:0] out_scale_y;
    logic [15:0]        out_phase;
    logic               updated;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic cap_in;
    logic clr;
    logic wr_key;
    logic mul_adv;
    logic upd_phase;
    logic idx_last;
    logic idx_dec;
    logic idx_inc;
    logic cap_i;
    logic cap_j;
    logic lane_start;
    logic div_init;
    logic div_step;
    logic lane_write;
    logic hold_key;
    logic emit;
    logic emit_upd;
    logic emit_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       cnt_zero;
    logic       t_gt_phase;
    logic       t_lt_phase;
    logic       idx_zero;
    logic       j_valid;
    logic       interp_ok;
    logic       div_done;
    logic       lane_last;
  } sts_t;

endpackage

// ===== sv/kfli_ram.sv =====
// generic simple dual port ram with registered read
module kfli_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/kfli_ctrl.sv =====
// sequencer for clear, append and tick items
module kfli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kfli_pkg::sts_t sts,
  output kfli_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MUL, S_PHASE, S_CHK, S_LRD, S_LCMP, S_SRD, S_SCMP,
    S_JCHK, S_JRD, S_JCAP, S_DECIDE, S_HOLD, S_LMUL, S_LINIT, S_LDIV,
    S_LWR, S_EMIT1
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          kfli_pkg::OP_CLEAR: begin
            cmd.clr   = 1'b1;
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
          kfli_pkg::OP_APPEND: begin
            cmd.wr_key      = !sts.full;
            cmd.emit        = 1'b1;
            cmd.emit_status = sts.full;
            state_nxt       = S_IDLE;
          end
          kfli_pkg::OP_TICK: begin
            state_nxt = S_MUL;
          end
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul_adv = 1'b1;
        state_nxt   = S_PHASE;
      end
      S_PHASE: begin
        cmd.upd_phase = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (sts.cnt_zero) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_last = 1'b1;
          state_nxt    = S_LRD;
        end
      end
      S_LRD: state_nxt = S_LCMP;
      S_LCMP: begin
        // phase past the last key: hold
        if (sts.t_lt_phase) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (!sts.t_gt_phase || sts.idx_zero) begin
          cmd.cap_i = 1'b1;
          state_nxt = S_JCHK;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (!sts.t_gt_phase || sts.idx_zero) begin
          cmd.cap_i = 1'b1;
          state_nxt = S_JCHK;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_JCHK: begin
        if (sts.j_valid) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_JRD;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_JRD: state_nxt = S_JCAP;
      S_JCAP: begin
        cmd.cap_j = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: state_nxt = sts.interp_ok ? S_LMUL : S_HOLD;
      S_HOLD: begin
        cmd.hold_key = 1'b1;
        state_nxt    = S_EMIT1;
      end
      S_LMUL: begin
        cmd.lane_start = 1'b1;
        state_nxt      = S_LINIT;
      end
      S_LINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_LDIV;
      end
      S_LDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_LWR;
        end
      end
      S_LWR: begin
        cmd.lane_write = 1'b1;
        state_nxt      = sts.lane_last ? S_EMIT1 : S_LMUL;
      end
      S_EMIT1: begin
        cmd.emit     = 1'b1;
        cmd.emit_upd = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/kfli_dp.sv =====
// key table, phase, search index, lane multiplier and serial divider
module kfli_dp #(
  parameter int MAX_KEYS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kfli_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  kfli_pkg::cmd_t      cmd,
  output kfli_pkg::sts_t      sts,
  output logic                out_valid,
  output kfli_pkg::out_item_t out_item
);

  localparam int CW   = $clog2(MAX_KEYS);
  localparam int CNTW = $clog2(MAX_KEYS + 1);

  logic [15:0] speed_r, wrap_r, phase_r;
  logic [CNTW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [63:0] held_r, vi_r, vj_r;
  logic [15:0] ti_r, tj_r;
  kfli_pkg::in_item_t in_r;
  logic [31:0] adv_r;
  logic signed [33:0] lprod_r;
  logic [1:0] lane_r;
  logic [15:0] rem_r;
  logic [31:0] dvd_r;
  logic neg_r;
  logic [kfli_pkg::DIV_CW-1:0] dcnt_r;
  logic out_valid_r;
  kfli_pkg::out_item_t out_r;

  logic [79:0] rdata;
  logic [15:0] rd_time;
  logic [24:0] sum;
  logic [15:0] dt, cur, va, vb, q16, res;
  logic signed [16:0] diff;
  logic [33:0] lmag;
  logic [16:0] rem_sh, rem_sub;
  logic ge;

  kfli_ram #(.WIDTH(80), .DEPTH(MAX_KEYS)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_key),
    .waddr (count_r[CW-1:0]),
    .wdata ({in_r.key_scale_y, in_r.key_scale_x, in_r.key_pos_y, in_r.key_pos_x,
             in_r.key_time}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign rd_time = rdata[15:0];
  assign sum     = {9'd0, phase_r} + {1'b0, adv_r[31:8]};
  assign dt      = tj_r - ti_r;
  assign cur     = phase_r - ti_r;
  assign va      = vi_r[{lane_r, 4'd0} +: 16];
  assign vb      = vj_r[{lane_r, 4'd0} +: 16];
  assign diff    = {vb[15], vb} - {va[15], va};
  assign lmag    = lprod_r[33] ? 34'(-lprod_r) : 34'(lprod_r);
  assign rem_sh  = {rem_r, dvd_r[31]};
  assign ge      = rem_sh >= {1'b0, dt};
  assign rem_sub = rem_sh - {1'b0, dt};
  assign q16     = dvd_r[15:0];
  assign res     = va + (neg_r ? 16'(-q16) : q16);

  always_comb begin
    sts            = '0;
    sts.op         = in_r.opcode;
    sts.full       = (count_r == CNTW'(MAX_KEYS));
    sts.cnt_zero   = (count_r == '0);
    sts.t_gt_phase = (rd_time > phase_r);
    sts.t_lt_phase = (rd_time < phase_r);
    sts.idx_zero   = (idx_r == '0);
    sts.j_valid    = ({1'b0, CNTW'(idx_r)} + 1'b1) < {1'b0, count_r};
    sts.interp_ok  = (tj_r > ti_r) && (phase_r >= ti_r);
    sts.div_done   = (dcnt_r == kfli_pkg::DIV_CW'(kfli_pkg::DIV_STEPS - 1));
    sts.lane_last  = (lane_r == 2'd3);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= kfli_pkg::FRAME_SPEED_RST;
      wrap_r      <= kfli_pkg::WRAP_LIMIT_RST;
      phase_r     <= '0;
      count_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == kfli_pkg::CFG_FRAME_SPEED) begin
          speed_r <= cfg_wdata;
        end else begin
          wrap_r <= cfg_wdata;
        end
      end
      if (cmd.clr) begin
        count_r <= '0;
      end else if (cmd.wr_key) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.upd_phase) begin
        phase_r <= (sum > {9'd0, wrap_r}) ? 16'd0 : sum[15:0];
      end
      if (cmd.hold_key) begin
        held_r <= vi_r;
      end else if (cmd.lane_write) begin
        held_r[{lane_r, 4'd0} +: 16] <= res;
      end
      out_valid_r <= cmd.emit;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_item;
    end
    if (cmd.mul_adv) begin
      adv_r <= speed_r * in_r.time_step;
    end
    if (cmd.idx_last) begin
      idx_r <= CW'(count_r - 1'b1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.cap_i) begin
      ti_r   <= rd_time;
      vi_r   <= rdata[79:16];
      lane_r <= 2'd0;
    end else if (cmd.lane_write) begin
      lane_r <= lane_r + 1'b1;
    end
    if (cmd.cap_j) begin
      tj_r <= rd_time;
      vj_r <= rdata[79:16];
    end
    if (cmd.lane_start) begin
      lprod_r <= diff * $signed({1'b0, cur});
    end
    if (cmd.div_init) begin
      neg_r  <= lprod_r[33];
      dvd_r  <= lmag[31:0];
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? rem_sub[15:0] : rem_sh[15:0];
      dvd_r  <= {dvd_r[30:0], ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.emit) begin
      out_r.out_pos_x   <= held_r[15:0];
      out_r.out_pos_y   <= held_r[31:16];
      out_r.out_scale_x <= held_r[47:32];
      out_r.out_scale_y <= held_r[63:48];
      out_r.out_phase   <= phase_r;
      out_r.updated     <= cmd.emit_upd;
      out_r.status      <= cmd.emit_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== sv/keyframe_linear_interpolator.sv =====
// top level of the keyframe linear interpolator
//
// channel   ports                          handshake
// input     start, busy, in_item           taken when start high and busy low
// result    out_valid, out_item            one-cycle strobe, cannot be held off
// config    cfg_we, cfg_index, cfg_wdata   written when cfg_we high
//
// clear and append items are answered straight from the dispatch state with a result strobe
// a tick runs the backward search over the key table and, when it interpolates,
// the serial divider (32 steps per value, four values)
// the search reads the key table one entry at a time through its ram port (read state, then compare state)
// reset (rst_n low, synchronous) empties the table and zeroes phase, held values and out_valid
// results are never stalled; one item is in flight at a time
module keyframe_linear_interpolator #(
  parameter int MAX_KEYS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kfli_pkg::in_item_t  in_item,
  output logic                out_valid,
  output kfli_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  // command and status between sequencer and datapath
  kfli_pkg::cmd_t cmd;
  kfli_pkg::sts_t sts;

  kfli_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // table memory, phase, interpolation arithmetic and output register
  kfli_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
